>>> rtl/dmtc_pkg.sv
// Shared types and constants of the direct-mapped translation cache.
package dmtc_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int VPAGE_W    = ADDR_W - PAGE_SHIFT;
  localparam int COUNT_W    = 5;
  localparam int RANGE_LIMIT = 16;
  // Fixed-point scale of the reciprocal used to split a page number into slot and rest.
  localparam int RECIP_SHIFT = VPAGE_W;

  typedef enum logic [2:0] {
    OP_LOOKUP_RD = 3'd0,
    OP_LOOKUP_WR = 3'd1,
    OP_INSERT_RD = 3'd2,
    OP_INSERT_WR = 3'd3,
    OP_INVAL_RD  = 3'd4,
    OP_INVAL_WR  = 3'd5,
    OP_INVAL_ALL = 3'd6
  } op_t;

  typedef struct packed {
    logic               en;
    op_t                op;
    logic [COUNT_W-1:0] count;
  } mask_cmd_t;

endpackage

>>> rtl/dmtc_if.sv
// Request and response channel interfaces of the translation cache.
interface dmtc_req_if import dmtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [ADDR_W-1:0]  virt_addr;
  logic [ADDR_W-1:0]  phys_addr;
  logic [COUNT_W-1:0] range_count;

  modport source (output valid, opcode, virt_addr, phys_addr, range_count, input ready);
  modport sink (input valid, opcode, virt_addr, phys_addr, range_count, output ready);
endinterface

interface dmtc_rsp_if import dmtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [ADDR_W-1:0] phys_page;

  modport source (output valid, hit, phys_page, input ready);
  modport sink (input valid, hit, phys_page, output ready);
endinterface

>>> rtl/dmtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dmtc_slot_div.sv
// Page number to slot reduction: reciprocal multiply, then one correction step.
module dmtc_slot_div import dmtc_pkg::*; #(
  parameter int ENTRIES = 64,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic               clk,
  input  logic               en,
  input  logic [VPAGE_W-1:0] vpage_in,
  output logic [VPAGE_W-1:0] vpage,
  output logic [IDX_W-1:0]   slot
);

  localparam logic [VPAGE_W-1:0] RECIP = VPAGE_W'((1 << RECIP_SHIFT) / ENTRIES);
  localparam int QN_W = VPAGE_W + IDX_W + 1;

  logic [2*VPAGE_W-1:0] prod;
  logic [VPAGE_W-1:0]   quot;
  logic [QN_W-1:0]      quot_n;
  logic [VPAGE_W-1:0]   rem;
  logic [IDX_W:0]       rem_lo;
  logic [IDX_W:0]       rem_fix;

  assign prod = (2*VPAGE_W)'(vpage_in) * (2*VPAGE_W)'(RECIP);

  // The estimate is the true quotient or one less, so the rest stays below twice ENTRIES.
  always_ff @(posedge clk) begin
    if (en) begin
      quot  <= prod[2*VPAGE_W-1:RECIP_SHIFT];
      vpage <= vpage_in;
    end
  end

  assign quot_n  = QN_W'(quot) * QN_W'(ENTRIES);
  assign rem     = vpage - quot_n[VPAGE_W-1:0];
  assign rem_lo  = rem[IDX_W:0];
  assign rem_fix = (rem_lo >= (IDX_W+1)'(ENTRIES)) ? rem_lo - (IDX_W+1)'(ENTRIES) : rem_lo;
  assign slot    = rem_fix[IDX_W-1:0];

endmodule

>>> rtl/dmtc_valid_masks.sv
// Read-valid, write-valid and written masks with insert, range invalidate and invalidate-all updates.
module dmtc_valid_masks import dmtc_pkg::*; #(
  parameter int ENTRIES = 64,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  mask_cmd_t        cmd,
  input  logic [IDX_W-1:0] slot,
  output logic             rd_bit,
  output logic             wr_bit,
  output logic             written_bit
);

  localparam int SUM_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

  logic [ENTRIES-1:0] rd_mask;
  logic [ENTRIES-1:0] wr_mask;
  logic [ENTRIES-1:0] written;
  logic [ENTRIES-1:0] rd_mask_next;
  logic [ENTRIES-1:0] wr_mask_next;
  logic [ENTRIES-1:0] written_next;
  logic [ENTRIES-1:0] span;
  logic [SUM_W-1:0]   span_end;
  logic               clear_whole;

  assign span_end    = SUM_W'(slot) + SUM_W'(cmd.count);
  assign clear_whole = (cmd.count > COUNT_W'(RANGE_LIMIT));

  // Span of slots hit by a range invalidate; it stops at the last slot and never wraps.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      span[i] = (SUM_W'(i) >= SUM_W'(slot)) && (SUM_W'(i) < span_end);
    end
  end

  always_comb begin
    rd_mask_next = rd_mask;
    wr_mask_next = wr_mask;
    written_next = written;
    if (cmd.en) begin
      case (cmd.op)
        OP_LOOKUP_RD, OP_LOOKUP_WR: begin
        end
        OP_INSERT_RD: begin
          rd_mask_next[slot] = 1'b1;
          written_next[slot] = 1'b1;
        end
        OP_INSERT_WR: begin
          wr_mask_next[slot] = 1'b1;
          written_next[slot] = 1'b1;
        end
        OP_INVAL_RD: begin
          rd_mask_next = clear_whole ? '0 : (rd_mask & ~span);
        end
        OP_INVAL_WR: begin
          wr_mask_next = clear_whole ? '0 : (wr_mask & ~span);
        end
        OP_INVAL_ALL: begin
          rd_mask_next = '0;
          wr_mask_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_mask <= '0;
      wr_mask <= '0;
      written <= '0;
    end else begin
      rd_mask <= rd_mask_next;
      wr_mask <= wr_mask_next;
      written <= written_next;
    end
  end

  assign rd_bit      = rd_mask[slot];
  assign wr_bit      = wr_mask[slot];
  assign written_bit = written[slot];

  a_insert_rd_sets: assert property (@(posedge clk) disable iff (rst)
    (cmd.en && cmd.op == OP_INSERT_RD) |=> (rd_mask[$past(slot)] && written[$past(slot)]))
    else $error("read insert did not validate its slot");

  a_insert_rd_keeps_wr: assert property (@(posedge clk) disable iff (rst)
    (cmd.en && cmd.op == OP_INSERT_RD) |=> $stable(wr_mask))
    else $error("read insert changed the write mask");

  a_inval_all_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.en && cmd.op == OP_INVAL_ALL) |=> (rd_mask == '0 && wr_mask == '0))
    else $error("invalidate all left a valid slot");

endmodule

>>> rtl/direct_mapped_translation_cache.sv
// Path: an accepted item moves through registers A, B, C and D to the result register R.
// Throughput: one item per cycle; a held result stalls the whole pipeline, and the
//   request side is ready whenever the result register is empty or being taken.
// Reset: the valid masks and per-slot written bits clear on reset, so unwritten
//   slots read as zero at once; no clearing pass is needed and items are taken right away.
module direct_mapped_translation_cache import dmtc_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input logic       clk,
  input logic       rst,
  dmtc_req_if.sink  req,
  dmtc_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  // The pipeline has five register levels:
  //   A  the accepted item (page numbers split out of the addresses),
  //   B  the reciprocal quotient inside the slot divider,
  //   C  the slot is known; masks are updated and the RAM is written or read here,
  //   D  the RAM read data and the sampled mask bits are present,
  //   R  the result register that drives the response channel.
  // Every item touches state only in stage C, in order, so an insert is seen by the
  // very next item without any forwarding.

  logic advance;

  // Stage A
  logic               a_valid;
  op_t                a_op;
  logic [VPAGE_W-1:0] a_vpage;
  logic [VPAGE_W-1:0] a_ppage;
  logic [COUNT_W-1:0] a_count;

  // Stage B
  logic               b_valid;
  op_t                b_op;
  logic [VPAGE_W-1:0] b_ppage;
  logic [COUNT_W-1:0] b_count;
  logic [VPAGE_W-1:0] b_vpage;
  logic [IDX_W-1:0]   b_slot;

  // Stage C
  logic               c_valid;
  op_t                c_op;
  logic [VPAGE_W-1:0] c_vpage;
  logic [VPAGE_W-1:0] c_ppage;
  logic [COUNT_W-1:0] c_count;
  logic [IDX_W-1:0]   c_slot;
  logic               c_insert;
  logic               c_rd_bit;
  logic               c_wr_bit;
  logic               c_written;
  mask_cmd_t          mask_cmd;

  // Stage D
  logic                 d_valid;
  logic                 d_lookup;
  logic                 d_vbit;
  logic                 d_written;
  logic [VPAGE_W-1:0]   d_vpage;
  logic [2*VPAGE_W-1:0] d_entry;
  logic [VPAGE_W-1:0]   d_tag;
  logic [VPAGE_W-1:0]   d_page;
  logic                 d_hit;

  // Result register
  logic              rsp_valid;
  logic              rsp_hit;
  logic [ADDR_W-1:0] rsp_page;

  // The whole pipeline moves together; it only stops while a result is held.
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= req.valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_op    <= op_t'(req.opcode);
      a_vpage <= req.virt_addr[ADDR_W-1:PAGE_SHIFT];
      a_ppage <= req.phys_addr[ADDR_W-1:PAGE_SHIFT];
      a_count <= req.range_count;
      b_op    <= a_op;
      b_ppage <= a_ppage;
      b_count <= a_count;
    end
  end

  dmtc_slot_div #(.ENTRIES(ENTRIES)) u_slot_div (
    .clk      (clk),
    .en       (advance),
    .vpage_in (a_vpage),
    .vpage    (b_vpage),
    .slot     (b_slot)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      c_op    <= b_op;
      c_vpage <= b_vpage;
      c_ppage <= b_ppage;
      c_count <= b_count;
      c_slot  <= b_slot;
    end
  end

  // State access of stage C: masks, then the shared tag and page RAM.
  assign mask_cmd.en    = advance && c_valid;
  assign mask_cmd.op    = c_op;
  assign mask_cmd.count = c_count;

  dmtc_valid_masks #(.ENTRIES(ENTRIES)) u_masks (
    .clk         (clk),
    .rst         (rst),
    .cmd         (mask_cmd),
    .slot        (c_slot),
    .rd_bit      (c_rd_bit),
    .wr_bit      (c_wr_bit),
    .written_bit (c_written)
  );

  assign c_insert = (c_op == OP_INSERT_RD) || (c_op == OP_INSERT_WR);

  dmtc_ram #(.WIDTH(2*VPAGE_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (advance && c_valid && c_insert),
    .waddr (c_slot),
    .wdata ({c_vpage, c_ppage}),
    .re    (advance),
    .raddr (c_slot),
    .rdata (d_entry)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      d_lookup  <= (c_op == OP_LOOKUP_RD) || (c_op == OP_LOOKUP_WR);
      d_vbit    <= (c_op == OP_LOOKUP_RD) ? c_rd_bit : c_wr_bit;
      d_written <= c_written;
      d_vpage   <= c_vpage;
    end
  end

  // A slot never written since reset reads as a zero tag and zero page.
  assign d_tag  = d_written ? d_entry[2*VPAGE_W-1:VPAGE_W] : '0;
  assign d_page = d_written ? d_entry[VPAGE_W-1:0] : '0;
  assign d_hit  = d_lookup && d_vbit && (d_tag == d_vpage);

  // Lookups report the stored page whether or not they hit; other operations report zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_hit  <= d_hit;
      rsp_page <= d_lookup ? {d_page, {PAGE_SHIFT{1'b0}}} : '0;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.phys_page = rsp_page;

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_slot < IDX_W'(ENTRIES - 1) || b_slot == IDX_W'(ENTRIES - 1)))
    else $error("slot divider produced a slot past the last entry");

  a_hit_needs_write: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_hit) |-> d_written)
    else $error("hit reported on a slot that was never written");

  a_non_lookup_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && d_valid && !d_lookup) |=> (rsp_valid && !rsp_hit && rsp_page == '0))
    else $error("non-lookup operation produced a nonzero result");

endmodule
